// ----- src/bres_pkg.sv -----
// Package for the Bresenham line rasterizer.
// Holds coordinate widths, request/response payloads and the line state record.
// No dependencies.
package bres_pkg;

    localparam int COORD_BITS = 10;
    localparam int INC_BITS   = COORD_BITS + 2;
    localparam int ERR_BITS   = COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_ADVANCE = 1'b1
    } t_op;

    typedef struct packed {
        t_op    op;
        t_coord x_start;
        t_coord y_start;
        t_coord x_end;
        t_coord y_end;
    } t_req;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   pixel_valid;
        logic   last_pixel;
    } t_rsp;

    typedef struct packed {
        t_coord                     walk_x;
        t_coord                     walk_y;
        logic signed [ERR_BITS-1:0] error_term;
        t_coord                     major_end;
        logic signed [INC_BITS-1:0] step_gain;
        logic signed [INC_BITS-1:0] step_correction;
        logic                       steep_line;
        logic                       falling_line;
        logic                       line_active;
    } t_line;

endpackage

// ----- src/bres_setup.sv -----
// Line setup: orders the endpoints, picks major axis and minor direction,
// and derives start point, start error and doubled increments.
// Depends on bres_pkg.
module bres_setup (
    input  bres_pkg::t_req  i_req,
    output bres_pkg::t_line o_line
);

    logic                                 swap;
    bres_pkg::t_coord                     ax;
    bres_pkg::t_coord                     ay;
    bres_pkg::t_coord                     cx;
    bres_pkg::t_coord                     cy;
    logic                                 falling;
    logic                                 steep;
    logic signed [bres_pkg::COORD_BITS:0] dy;
    bres_pkg::t_coord                     adx;
    bres_pkg::t_coord                     ady;
    bres_pkg::t_coord                     mag_major;
    bres_pkg::t_coord                     mag_minor;
    logic signed [bres_pkg::ERR_BITS-1:0] major_e;
    logic signed [bres_pkg::INC_BITS-1:0] major_i;
    logic signed [bres_pkg::INC_BITS-1:0] minor_i;

    always_comb begin
        swap = i_req.x_start > i_req.x_end;
        if (swap) begin
            ax      = i_req.x_end;
            ay      = i_req.y_end;
            cx      = i_req.x_start;
            cy      = i_req.y_start;
            falling = i_req.y_start <= i_req.y_end;
        end else begin
            ax      = i_req.x_start;
            ay      = i_req.y_start;
            cx      = i_req.x_end;
            cy      = i_req.y_end;
            falling = i_req.y_start > i_req.y_end;
        end

        dy  = $signed({1'b0, cy}) - $signed({1'b0, ay});
        adx = cx - ax;
        if (dy[bres_pkg::COORD_BITS]) begin
            ady = bres_pkg::t_coord'(-dy);
        end else begin
            ady = bres_pkg::t_coord'(dy);
        end
        steep = ady > adx;

        mag_major = steep ? ady : adx;
        mag_minor = steep ? adx : ady;
        major_e   = $signed({{(bres_pkg::ERR_BITS - bres_pkg::COORD_BITS){1'b0}}, mag_major});
        major_i   = $signed({{(bres_pkg::INC_BITS - bres_pkg::COORD_BITS - 1){1'b0}},
                             mag_major, 1'b0});
        minor_i   = $signed({{(bres_pkg::INC_BITS - bres_pkg::COORD_BITS - 1){1'b0}},
                             mag_minor, 1'b0});

        o_line              = '0;
        o_line.steep_line   = steep;
        o_line.falling_line = falling;
        o_line.line_active  = 1'b1;

        if (falling && steep) begin
            o_line.walk_x = cx;
            o_line.walk_y = cy;
        end else begin
            o_line.walk_x = ax;
            o_line.walk_y = ay;
        end

        if (!steep) begin
            o_line.major_end = cx;
        end else if (falling) begin
            o_line.major_end = ay;
        end else begin
            o_line.major_end = cy;
        end

        if (falling) begin
            o_line.error_term      = major_e;
            o_line.step_gain       = -minor_i;
            o_line.step_correction = major_i;
        end else begin
            o_line.error_term      = -major_e;
            o_line.step_gain       = minor_i;
            o_line.step_correction = -major_i;
        end
    end

endmodule

// ----- src/bres_advance.sv -----
// One Bresenham step: updates the error term and walks one unit on the
// major axis, stepping the minor axis when the tie rule says so.
// Depends on bres_pkg.
module bres_advance (
    input  bres_pkg::t_line i_line,
    output bres_pkg::t_line o_line
);

    logic signed [bres_pkg::ERR_BITS-1:0] gain_e;
    logic signed [bres_pkg::ERR_BITS-1:0] corr_e;
    logic signed [bres_pkg::ERR_BITS-1:0] e_skip;
    logic signed [bres_pkg::ERR_BITS-1:0] e_step;
    logic                                 minor_step;

    always_comb begin
        gain_e = $signed({i_line.step_gain[bres_pkg::INC_BITS-1], i_line.step_gain});
        corr_e = $signed({i_line.step_correction[bres_pkg::INC_BITS-1],
                          i_line.step_correction});
        e_skip = i_line.error_term + gain_e;
        e_step = e_skip + corr_e;

        // falling lines step on err <= 0, rising on err >= 0
        if (i_line.falling_line) begin
            minor_step = e_skip[bres_pkg::ERR_BITS-1] || (e_skip == '0);
        end else begin
            minor_step = !e_skip[bres_pkg::ERR_BITS-1];
        end

        o_line            = i_line;
        o_line.error_term = minor_step ? e_step : e_skip;

        if (minor_step) begin
            if (i_line.steep_line) begin
                o_line.walk_x = i_line.falling_line ? i_line.walk_x - bres_pkg::t_coord'(1)
                                                    : i_line.walk_x + bres_pkg::t_coord'(1);
            end else begin
                o_line.walk_y = i_line.falling_line ? i_line.walk_y - bres_pkg::t_coord'(1)
                                                    : i_line.walk_y + bres_pkg::t_coord'(1);
            end
        end

        if (i_line.steep_line) begin
            o_line.walk_y = i_line.walk_y + bres_pkg::t_coord'(1);
        end else begin
            o_line.walk_x = i_line.walk_x + bres_pkg::t_coord'(1);
        end
    end

endmodule

// ----- src/bresenham_line_rasterizer.sv -----
// Bresenham line rasterizer, all octants, one pixel per request. A load request
// carries two endpoints and returns the first pixel; each advance request returns
// the next pixel, with last_pixel set on the final one, or a response with
// pixel_valid low when no line is active. A request is taken into an input
// register, and its response is written to the result register from there unless
// the output stalls; one request is accepted every cycle while the output does not
// stall, as the error update between the two registers is combinational.
// Depends on bres_pkg, bres_setup and bres_advance.
module bresenham_line_rasterizer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  bres_pkg::t_req i_in_req,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output bres_pkg::t_rsp o_out_rsp
);

    logic            r_in_valid;
    bres_pkg::t_req  r_in_req;
    bres_pkg::t_line r_line;
    bres_pkg::t_line n_line;
    logic            r_out_valid;
    bres_pkg::t_rsp  r_out_rsp;
    bres_pkg::t_rsp  n_rsp;

    bres_pkg::t_line setup_line;
    bres_pkg::t_line adv_line;
    bres_pkg::t_line cand;
    bres_pkg::t_coord major;
    logic            is_load;
    logic            emit;
    logic            last;
    logic            fire;

    bres_setup u_setup (
        .i_req  (r_in_req),
        .o_line (setup_line)
    );

    bres_advance u_advance (
        .i_line (r_line),
        .o_line (adv_line)
    );

    always_comb begin
        fire       = r_in_valid && (!r_out_valid || !i_out_stall);
        o_in_stall = r_in_valid && !fire;

        is_load = r_in_req.op == bres_pkg::OP_LOAD;
        cand    = is_load ? setup_line : adv_line;
        emit    = is_load || r_line.line_active;
        major   = cand.steep_line ? cand.walk_y : cand.walk_x;
        last    = major == cand.major_end;

        if (emit) begin
            n_line             = cand;
            n_line.line_active = !last;
            n_rsp.pixel_x      = cand.walk_x;
            n_rsp.pixel_y      = cand.walk_y;
            n_rsp.pixel_valid  = 1'b1;
            n_rsp.last_pixel   = last;
        end else begin
            n_line = r_line;
            n_rsp  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_line      <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_line      <= n_line;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_req <= i_in_req;
        end
        if (fire) begin
            r_out_rsp <= n_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule
